// File: hw/rtl/smk_pkg.sv
// Shared types and constants of the snapshot marker engine.
package smk_pkg;

	localparam int MAX_RESULTS = 10;
	localparam int RCW = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_MARKER  = 2'd1;
	localparam logic [1:0] KIND_MESSAGE = 2'd2;

	localparam logic [1:0] REG_SELF_NODE  = 2'd0;
	localparam logic [1:0] REG_IN_MASK    = 2'd1;
	localparam logic [1:0] REG_OUT_MASK   = 2'd2;

	typedef enum logic [2:0] {
		ACT_CAPTURE  = 3'd0,
		ACT_MARKER   = 3'd1,
		ACT_RECORD   = 3'd2,
		ACT_COMPLETE = 3'd3,
		ACT_FULL     = 3'd4
	} smk_act_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_FULL,
		ST_CAPTURE,
		ST_MARKER,
		ST_CHECK,
		ST_COMPLETE,
		ST_SCAN,
		ST_RECORD
	} smk_state_t;

	typedef struct packed {
		logic     clr;
		logic     accept;
		logic     claim;
		logic     close;
		logic     emit;
		smk_act_t act;
		logic     last;
		logic     mk_load;
		logic     mk_next;
		logic     finish;
		logic     scan_init;
		logic     scan_step;
		logic     rec_next;
	} smk_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [1:0] kind;
		logic       finished;
		logic       hit;
		logic       free_any;
		logic       rec_none;
		logic       pend_zero;
		logic       mk_any;
		logic       mk_more;
		logic       out_free;
		logic       scan_last;
		logic       scan_hit;
		logic       rec_last;
	} smk_stat_t;

endpackage

// File: hw/rtl/smk_ram.sv
// Generic single-port RAM with registered read.
module smk_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: hw/rtl/smk_ctrl.sv
// Controller state machine of the snapshot marker engine.
module smk_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  smk_pkg::smk_stat_t stat,
	output logic             s_tready,
	output smk_pkg::smk_cmd_t  cmd
);

	smk_pkg::smk_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smk_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smk_pkg::ST_CLEAR: begin
				if (stat.clr_last) state_d = smk_pkg::ST_IDLE;
			end
			smk_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = smk_pkg::ST_LOOKUP;
			end
			smk_pkg::ST_LOOKUP: begin
				unique case (stat.kind)
					smk_pkg::KIND_START: begin
						if (stat.finished || stat.hit) state_d = smk_pkg::ST_IDLE;
						else if (stat.free_any) state_d = smk_pkg::ST_CAPTURE;
						else state_d = smk_pkg::ST_FULL;
					end
					smk_pkg::KIND_MARKER: begin
						if (stat.finished) state_d = smk_pkg::ST_IDLE;
						else if (stat.hit) state_d = smk_pkg::ST_CHECK;
						else if (stat.free_any) state_d = smk_pkg::ST_CAPTURE;
						else state_d = smk_pkg::ST_FULL;
					end
					smk_pkg::KIND_MESSAGE: begin
						state_d = stat.rec_none ? smk_pkg::ST_IDLE : smk_pkg::ST_SCAN;
					end
					default: state_d = smk_pkg::ST_IDLE;
				endcase
			end
			smk_pkg::ST_FULL: begin
				if (stat.out_free) state_d = smk_pkg::ST_IDLE;
			end
			smk_pkg::ST_CAPTURE: begin
				if (stat.out_free) begin
					if (stat.mk_any) state_d = smk_pkg::ST_MARKER;
					else if (stat.pend_zero) state_d = smk_pkg::ST_COMPLETE;
					else state_d = smk_pkg::ST_IDLE;
				end
			end
			smk_pkg::ST_MARKER: begin
				if (stat.out_free) begin
					if (stat.mk_more) state_d = smk_pkg::ST_MARKER;
					else if (stat.pend_zero) state_d = smk_pkg::ST_COMPLETE;
					else state_d = smk_pkg::ST_IDLE;
				end
			end
			smk_pkg::ST_CHECK: begin
				state_d = stat.pend_zero ? smk_pkg::ST_COMPLETE : smk_pkg::ST_IDLE;
			end
			smk_pkg::ST_COMPLETE: begin
				if (stat.out_free) state_d = smk_pkg::ST_IDLE;
			end
			smk_pkg::ST_SCAN: begin
				if (stat.scan_last) begin
					state_d = stat.scan_hit ? smk_pkg::ST_RECORD : smk_pkg::ST_IDLE;
				end
			end
			smk_pkg::ST_RECORD: begin
				if (stat.out_free) begin
					state_d = stat.rec_last ? smk_pkg::ST_IDLE : smk_pkg::ST_SCAN;
				end
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.act  = smk_pkg::ACT_CAPTURE;
		s_tready = 1'b0;
		unique case (state_q)
			smk_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			smk_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			smk_pkg::ST_LOOKUP: begin
				unique case (stat.kind)
					smk_pkg::KIND_START: begin
						cmd.claim = !stat.finished && !stat.hit && stat.free_any;
					end
					smk_pkg::KIND_MARKER: begin
						cmd.claim = !stat.finished && !stat.hit && stat.free_any;
						cmd.close = !stat.finished && stat.hit;
					end
					smk_pkg::KIND_MESSAGE: begin
						cmd.scan_init = !stat.rec_none;
					end
					default: ;
				endcase
			end
			smk_pkg::ST_FULL: begin
				cmd.emit = stat.out_free;
				cmd.act  = smk_pkg::ACT_FULL;
				cmd.last = 1'b1;
			end
			smk_pkg::ST_CAPTURE: begin
				cmd.emit    = stat.out_free;
				cmd.act     = smk_pkg::ACT_CAPTURE;
				cmd.last    = !stat.mk_any && !stat.pend_zero;
				cmd.mk_load = stat.out_free;
			end
			smk_pkg::ST_MARKER: begin
				cmd.emit    = stat.out_free;
				cmd.act     = smk_pkg::ACT_MARKER;
				cmd.last    = !stat.mk_more && !stat.pend_zero;
				cmd.mk_next = stat.out_free;
			end
			smk_pkg::ST_CHECK: ;
			smk_pkg::ST_COMPLETE: begin
				cmd.emit   = stat.out_free;
				cmd.act    = smk_pkg::ACT_COMPLETE;
				cmd.last   = 1'b1;
				cmd.finish = stat.out_free;
			end
			smk_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			smk_pkg::ST_RECORD: begin
				cmd.emit     = stat.out_free;
				cmd.act      = smk_pkg::ACT_RECORD;
				cmd.last     = stat.rec_last;
				cmd.rec_next = stat.out_free;
			end
		endcase
	end

endmodule

// File: hw/rtl/smk_dp.sv
// Datapath: item latch, slot table, finished bitmap, scan logic and output register.
module smk_dp #(
	parameter int NODE_COUNT   = 8,
	parameter int ACTIVE_SLOTS = 4,
	parameter int SNAPSHOT_IDS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smk_pkg::smk_cmd_t  cmd,
	input  logic [31:0]        s_tdata,
	input  logic [1:0]         s_tuser,
	input  logic [2:0]         self_node,
	input  logic [7:0]         in_mask,
	input  logic [7:0]         out_mask,
	input  logic               m_tready,
	output smk_pkg::smk_stat_t stat,
	output logic               m_tvalid,
	output logic [31:0]        m_tdata,
	output logic [2:0]         m_tuser,
	output logic               m_tlast
);

	localparam int IDW = $clog2(SNAPSHOT_IDS);
	localparam int SW  = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
	localparam int CW  = $clog2(ACTIVE_SLOTS + 1);
	localparam int TW  = (CW > smk_pkg::RCW) ? CW : smk_pkg::RCW;
	localparam int CH  = (NODE_COUNT < 8) ? NODE_COUNT : 8;
	localparam logic [7:0] CH_LIM = 8'((1 << CH) - 1);

	// bitmap index table: id modulo SNAPSHOT_IDS
	logic [IDW-1:0] id_map [256];
	for (genvar g = 0; g < 256; g++) begin : g_map
		assign id_map[g] = IDW'(g % SNAPSHOT_IDS);
	end

	logic [1:0]  kind_q;
	logic [2:0]  origin_q;
	logic [7:0]  snap_q;
	logic [15:0] handle_q;

	logic        valid_q [ACTIVE_SLOTS];
	logic [7:0]  id_q    [ACTIVE_SLOTS];
	logic [7:0]  mask_q  [ACTIVE_SLOTS];
	logic [SW-1:0] cur_slot_q;

	logic [IDW-1:0] clr_cnt_q;
	logic [2:0]     chan_q;

	logic [SW-1:0] scan_idx_q;
	logic          found_q;
	logic          have_prev_q;
	logic [7:0]    best_id_q;
	logic [7:0]    prev_id_q;
	logic [smk_pkg::RCW-1:0] rec_cnt_q;
	logic [smk_pkg::RCW-1:0] rec_total_q;

	logic              out_valid_q;
	smk_pkg::smk_act_t out_act_q;
	logic [7:0]        out_snap_q;
	logic [2:0]        out_chan_q;
	logic [15:0]       out_handle_q;
	logic [2:0]        out_node_q;
	logic              out_last_q;

	logic [7:0]    obit;
	logic [7:0]    closed;
	logic          hit;
	logic [SW-1:0] hit_slot;
	logic          free_any;
	logic [SW-1:0] free_slot;
	logic [TW-1:0] rec_cnt_n;
	logic [smk_pkg::RCW-1:0] rec_total_n;
	logic [7:0]    elig;
	logic [2:0]    mk_first;
	logic [2:0]    mk_nxt;
	logic          mk_more;
	logic          cand;
	logic          scan_last;

	logic           ram_we;
	logic [IDW-1:0] ram_addr;
	logic           ram_rdata;

	assign obit   = 8'(1) << origin_q;
	assign closed = (kind_q == smk_pkg::KIND_MARKER) ? obit : 8'd0;

	always_comb begin
		hit       = 1'b0;
		hit_slot  = '0;
		free_any  = 1'b0;
		free_slot = '0;
		rec_cnt_n = '0;
		for (int s = 0; s < ACTIVE_SLOTS; s++) begin
			if (valid_q[s] && id_q[s] == snap_q) begin
				hit      = 1'b1;
				hit_slot = SW'(s);
			end
			if (valid_q[s] && mask_q[s][origin_q]) begin
				rec_cnt_n = rec_cnt_n + TW'(1);
			end
		end
		for (int s = ACTIVE_SLOTS - 1; s >= 0; s--) begin
			if (!valid_q[s]) begin
				free_any  = 1'b1;
				free_slot = SW'(s);
			end
		end
	end

	assign rec_total_n = (rec_cnt_n > TW'(smk_pkg::MAX_RESULTS)) ?
		smk_pkg::RCW'(smk_pkg::MAX_RESULTS) : smk_pkg::RCW'(rec_cnt_n);

	assign elig = out_mask & CH_LIM;

	always_comb begin
		mk_first = '0;
		mk_nxt   = '0;
		mk_more  = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (elig[i]) begin
				mk_first = 3'(i);
			end
			if (elig[i] && i > int'(chan_q)) begin
				mk_more = 1'b1;
				mk_nxt  = 3'(i);
			end
		end
	end

	assign cand = valid_q[scan_idx_q] && mask_q[scan_idx_q][origin_q] &&
		(!have_prev_q || id_q[scan_idx_q] > prev_id_q) &&
		(!found_q || id_q[scan_idx_q] < best_id_q);
	assign scan_last = (scan_idx_q == SW'(ACTIVE_SLOTS - 1));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q   <= s_tuser[1:0];
			origin_q <= s_tdata[2:0];
			snap_q   <= s_tdata[10:3];
			handle_q <= s_tdata[26:11];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < ACTIVE_SLOTS; s++) begin
				valid_q[s] <= 1'b0;
			end
		end else begin
			if (cmd.claim) valid_q[free_slot] <= 1'b1;
			if (cmd.finish) valid_q[cur_slot_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.claim) begin
			id_q[free_slot]   <= snap_q;
			mask_q[free_slot] <= in_mask & ~closed;
			cur_slot_q        <= free_slot;
		end
		if (cmd.close) begin
			mask_q[hit_slot] <= mask_q[hit_slot] & ~obit;
			cur_slot_q       <= hit_slot;
		end
		if (cmd.mk_load) chan_q <= mk_first;
		if (cmd.mk_next) chan_q <= mk_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			scan_idx_q  <= '0;
			found_q     <= 1'b0;
			have_prev_q <= 1'b0;
			rec_cnt_q   <= '0;
			rec_total_q <= '0;
		end else begin
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + IDW'(1);
			if (cmd.scan_init) begin
				scan_idx_q  <= '0;
				found_q     <= 1'b0;
				have_prev_q <= 1'b0;
				rec_cnt_q   <= '0;
				rec_total_q <= rec_total_n;
			end
			if (cmd.scan_step) begin
				if (cand) found_q <= 1'b1;
				scan_idx_q <= scan_last ? '0 : scan_idx_q + SW'(1);
			end
			if (cmd.rec_next) begin
				have_prev_q <= 1'b1;
				found_q     <= 1'b0;
				scan_idx_q  <= '0;
				rec_cnt_q   <= rec_cnt_q + smk_pkg::RCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && cand) best_id_q <= id_q[scan_idx_q];
		if (cmd.rec_next) prev_id_q <= best_id_q;
	end

	assign ram_we = cmd.clr || cmd.finish;

	always_comb begin
		priority if (cmd.clr) begin
			ram_addr = clr_cnt_q;
		end else if (cmd.finish) begin
			ram_addr = id_map[snap_q];
		end else begin
			ram_addr = id_map[s_tdata[10:3]];
		end
	end

	smk_ram #(
		.WIDTH(1),
		.DEPTH(SNAPSHOT_IDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (cmd.finish),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_act_q    <= cmd.act;
			out_last_q   <= cmd.last;
			out_snap_q   <= (cmd.act == smk_pkg::ACT_RECORD) ? best_id_q : snap_q;
			out_chan_q   <= (cmd.act == smk_pkg::ACT_MARKER) ? chan_q :
				(cmd.act == smk_pkg::ACT_RECORD) ? origin_q : 3'd0;
			out_handle_q <= (cmd.act == smk_pkg::ACT_RECORD) ? handle_q : 16'd0;
			out_node_q   <= (cmd.act == smk_pkg::ACT_COMPLETE) ? self_node : 3'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_act_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_node_q, out_handle_q, out_chan_q, out_snap_q};

	always_comb begin
		stat           = '0;
		stat.clr_last  = (clr_cnt_q == IDW'(SNAPSHOT_IDS - 1));
		stat.kind      = kind_q;
		stat.finished  = ram_rdata;
		stat.hit       = hit;
		stat.free_any  = free_any;
		stat.rec_none  = (rec_cnt_n == '0);
		stat.pend_zero = (mask_q[cur_slot_q] == 8'd0);
		stat.mk_any    = |elig;
		stat.mk_more   = mk_more;
		stat.out_free  = !out_valid_q || m_tready;
		stat.scan_last = scan_last;
		stat.scan_hit  = found_q || cand;
		stat.rec_last  = (rec_cnt_q + smk_pkg::RCW'(1) == rec_total_q);
	end

endmodule

// File: hw/rtl/snapshot_marker_engine.sv
// Top level of the snapshot marker engine: config registers, controller, datapath.
//
// Channel  Kind         Beat contents
// s_*      stream in    one event: kind, origin channel, snapshot id, message handle
// m_*      stream out   one result: action, snapshot id, channel, handle, node, last
// p*       APB          self_node @0x0, input_channel_mask @0x4, output_channel_mask @0x8
//
// Each event takes an accept state and a lookup state, then one state per
// capture/marker/complete result; a marker for an active snapshot adds a check state.
// A message event walks the slot table once per record result before emitting it.
// After reset the finished bitmap RAM is cleared, one entry a cycle, over all SNAPSHOT_IDS
// entries; s_tready stays low meanwhile. A stalled m_tready holds the one-entry
// output register and the sequencer.
module snapshot_marker_engine #(
	parameter int NODE_COUNT   = 8,
	parameter int ACTIVE_SLOTS = 4,
	parameter int SNAPSHOT_IDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // origin_channel[2:0], snapshot_number[10:3], message_handle[26:11]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_snapshot[7:0], channel[10:8], recorded_handle[26:11],
	                               // reporting_node[29:27]
	output logic [2:0]  m_tuser,   // action[2:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0] self_node_q;
	logic [7:0] in_mask_q;
	logic [7:0] out_mask_q;

	smk_pkg::smk_cmd_t  cmd;
	smk_pkg::smk_stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_node_q <= '0;
			in_mask_q   <= '0;
			out_mask_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				smk_pkg::REG_SELF_NODE: self_node_q <= pwdata[2:0];
				smk_pkg::REG_IN_MASK:   in_mask_q   <= pwdata[7:0];
				smk_pkg::REG_OUT_MASK:  out_mask_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			smk_pkg::REG_SELF_NODE: prdata = {29'd0, self_node_q};
			smk_pkg::REG_IN_MASK:   prdata = {24'd0, in_mask_q};
			smk_pkg::REG_OUT_MASK:  prdata = {24'd0, out_mask_q};
			default:                prdata = 32'd0;
		endcase
	end

	smk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	smk_dp #(
		.NODE_COUNT   (NODE_COUNT),
		.ACTIVE_SLOTS (ACTIVE_SLOTS),
		.SNAPSHOT_IDS (SNAPSHOT_IDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.self_node (self_node_q),
		.in_mask   (in_mask_q),
		.out_mask  (out_mask_q),
		.m_tready  (m_tready),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted on two back-to-back beats");

	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == smk_pkg::ACT_FULL) |-> m_tlast)
		else $error("table full result without tlast");

	a_complete_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == smk_pkg::ACT_COMPLETE) |-> m_tlast)
		else $error("completion result without tlast");

	a_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != smk_pkg::ACT_COMPLETE) |-> (m_tdata[29:27] == 3'd0))
		else $error("reporting node set on a non-completion result");

endmodule
